// ===== rtl/bpa_pkg.sv =====
// Shared widths, operation codes and register indexes of the bitmap page allocator.
package bpa_pkg;

  localparam int ADDR_W = 40;
  localparam int CNT_W  = 13;
  localparam int OP_W   = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [0:0] {
    REG_MEM_BASE   = 1'b0,
    REG_HELD_PAGES = 1'b1
  } reg_index_t;

  localparam logic [ADDR_W-1:0] MEM_BASE_RESET = 40'h00_8000_0000;
  localparam logic [CNT_W-1:0]  RESERVED_RESET = 13'd0;

endpackage

// ===== rtl/bpa_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module bpa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/bitmap_page_allocator.sv =====
// Bitmap first-fit page allocator: used map in a word-wide RAM, scanned and updated in place.
// Steps: init rewrites every map word; a bad allocate count or an unused code responds
//   without touching the map; free forms the offset, checks it, then clears the run per word
//   unless rejected or zero-count; allocate scans for a first fit, then sets that run.
// One operation in flight: the next request can transfer in the cycle after the response is loaded.
// Reset: registers take their reset values, then a clearing pass zeroes every map word.
module bitmap_page_allocator #(
  parameter int PAGE_COUNT = 4096,  // power of two, 8..65536
  parameter int PAGE_BYTES = 4096   // power of two, 512..65536
) (
  input  logic                         clk,
  input  logic                         rst,
  // request channel
  input  logic                         request_valid,
  output logic                         request_stall,
  input  logic [bpa_pkg::OP_W-1:0]     operation,
  input  logic [bpa_pkg::CNT_W-1:0]    page_count,
  input  logic [bpa_pkg::ADDR_W-1:0]   address,
  // response channel
  output logic                         response_valid,
  input  logic                         response_stall,
  output logic                         status,
  output logic [bpa_pkg::ADDR_W-1:0]   page_address,
  // configuration writes
  input  logic                         write_enable,
  input  logic [0:0]                   register_index,
  input  logic [bpa_pkg::ADDR_W-1:0]   write_data
);

  // map geometry: W pages per RAM word
  localparam int W      = (PAGE_COUNT < 64) ? PAGE_COUNT : 64;
  localparam int LOG_W  = $clog2(W);
  localparam int DEPTH  = PAGE_COUNT / W;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PI_W   = AW + LOG_W;               // page index (word, bit)
  localparam int PC_W   = $clog2(PAGE_COUNT + 1);
  localparam int CMP_W  = (PC_W > bpa_pkg::CNT_W) ? PC_W : bpa_pkg::CNT_W;
  localparam int FS_W   = CMP_W + 1;
  localparam int PB_SH  = $clog2(PAGE_BYTES);
  localparam int PG_W   = bpa_pkg::ADDR_W - PB_SH;
  localparam int ADDR_W = bpa_pkg::ADDR_W;
  localparam int CNT_W  = bpa_pkg::CNT_W;

  localparam logic [W-1:0]     ONES      = {W{1'b1}};
  localparam logic [AW-1:0]    LAST_WORD = AW'(DEPTH - 1);
  localparam logic [CMP_W-1:0] PC_C      = CMP_W'(PAGE_COUNT);

  typedef enum logic [2:0] {
    S_INIT,   // write sweep: reset clear or initialize
    S_IDLE,
    S_SCAN,   // first-fit search, one word a cycle
    S_ADDR,   // form the returned address
    S_FOFF,   // free: offset from mem_base
    S_FCHK,   // free: range and alignment checks
    S_RMW,    // set or clear the run, read-modify-write per word
    S_RESP
  } state_t;

  state_t state;

  // configuration
  logic [ADDR_W-1:0] mem_base;
  logic [CNT_W-1:0]  held_pages;

  // operation registers
  logic [CNT_W-1:0]  count_reg;
  logic [ADDR_W-1:0] address_reg;
  logic              init_reply;
  logic [CMP_W-1:0]  sweep_n;
  logic              res_status;
  logic [ADDR_W-1:0] res_addr;
  logic              free_below;
  logic [ADDR_W-1:0] free_off;
  logic [PI_W-1:0]   run_lo;
  logic [PI_W-1:0]   run_hi;
  logic              set_mode;

  // RAM sequencing
  logic [AW-1:0]     rd_word;
  logic              rd_active;
  logic              p1_valid;
  logic [AW-1:0]     p1_word;
  logic              p2_valid;
  logic [AW-1:0]     p2_word;
  logic [W-1:0]      a_has;
  logic [LOG_W-1:0]  a_dist [W];
  logic [CMP_W-1:0]  r_in;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [W-1:0]      ram_wdata;
  logic              ram_re;
  logic [W-1:0]      ram_rdata;

  bpa_ram #(
    .WIDTH (W),
    .DEPTH (DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_word),
    .rdata (ram_rdata)
  );

  assign request_stall = (state != S_IDLE);

  logic request_xfer;
  assign request_xfer = request_valid && !request_stall;

  // ---------------------------------------------------------------
  // Initialize sweep: words below n/W all used, word n/W partly used
  // ---------------------------------------------------------------
  logic [CMP_W-1:0] init_w;
  logic [CMP_W-1:0] init_nw;
  logic [LOG_W-1:0] init_nb;
  logic [W-1:0]     init_mask;

  always_comb begin
    init_w  = CMP_W'(rd_word);
    init_nw = sweep_n >> LOG_W;
    init_nb = sweep_n[LOG_W-1:0];
    if (init_w < init_nw) begin
      init_mask = ONES;
    end else if (init_w == init_nw) begin
      init_mask = ~(ONES << init_nb);
    end else begin
      init_mask = '0;
    end
  end

  // ---------------------------------------------------------------
  // Run sweep mask for the word being written back
  // ---------------------------------------------------------------
  logic [AW-1:0]    lo_word;
  logic [AW-1:0]    hi_word;
  logic [LOG_W-1:0] lo_bit;
  logic [LOG_W-1:0] hi_bit;
  logic [W-1:0]     run_mask;
  logic [W-1:0]     rmw_data;

  always_comb begin
    lo_word  = run_lo[PI_W-1:LOG_W];
    hi_word  = run_hi[PI_W-1:LOG_W];
    lo_bit   = run_lo[LOG_W-1:0];
    hi_bit   = run_hi[LOG_W-1:0];
    run_mask = ((p1_word == lo_word) ? (ONES << lo_bit) : ONES)
             & ((p1_word == hi_word) ? (ONES >> (~hi_bit)) : ONES);
    rmw_data = set_mode ? (ram_rdata | run_mask) : (ram_rdata & ~run_mask);
  end

  always_comb begin
    ram_re    = ((state == S_SCAN) || (state == S_RMW)) && rd_active;
    ram_we    = (state == S_INIT) || ((state == S_RMW) && p1_valid);
    ram_waddr = (state == S_INIT) ? rd_word : p1_word;
    ram_wdata = (state == S_INIT) ? init_mask : rmw_data;
  end

  // ---------------------------------------------------------------
  // Scan stage A: per bit, distance back to the nearest used bit in
  // the word (parallel prefix over log2(W) levels)
  // ---------------------------------------------------------------
  logic             pf_has [LOG_W+1][W];
  logic [LOG_W-1:0] pf_pos [LOG_W+1][W];
  logic [LOG_W-1:0] sa_dist [W];

  always_comb begin
    int src;
    for (int b = 0; b < W; b++) begin
      pf_has[0][b] = ram_rdata[b];
      pf_pos[0][b] = LOG_W'(b);
    end
    for (int l = 0; l < LOG_W; l++) begin
      for (int b = 0; b < W; b++) begin
        src = (b >= (1 << l)) ? (b - (1 << l)) : b;
        if (!pf_has[l][b] && (b >= (1 << l))) begin
          pf_has[l+1][b] = pf_has[l][src];
          pf_pos[l+1][b] = pf_pos[l][src];
        end else begin
          pf_has[l+1][b] = pf_has[l][b];
          pf_pos[l+1][b] = pf_pos[l][b];
        end
      end
    end
    for (int b = 0; b < W; b++) begin
      sa_dist[b] = LOG_W'(b) - pf_pos[LOG_W][b];
    end
  end

  // ---------------------------------------------------------------
  // Scan stage B: lowest bit whose run reaches the requested count
  // ---------------------------------------------------------------
  logic [CMP_W-1:0] count_ext;
  logic [CMP_W-1:0] need;
  logic [W-1:0]     qual;
  logic             sb_found;
  logic [LOG_W-1:0] sb_bit;
  logic [CMP_W-1:0] r_out;
  logic [PI_W-1:0]  sb_end;
  logic [PI_W-1:0]  sb_first;

  always_comb begin
    count_ext = CMP_W'(count_reg);
    need      = count_ext - r_in;
    for (int b = 0; b < W; b++) begin
      qual[b] = a_has[b] ? (CMP_W'(a_dist[b]) >= count_ext)
                         : (CMP_W'(b + 1) >= need);
    end
    sb_found = |qual;
    sb_bit   = '0;
    for (int b = W - 1; b >= 0; b--) begin
      if (qual[b]) begin
        sb_bit = LOG_W'(b);
      end
    end
    r_out    = a_has[W-1] ? CMP_W'(a_dist[W-1]) : (r_in + CMP_W'(W));
    sb_end   = {p2_word, sb_bit};
    sb_first = PI_W'(CMP_W'(sb_end) + CMP_W'(1) - count_ext);
  end

  // ---------------------------------------------------------------
  // Free checks
  // ---------------------------------------------------------------
  logic [ADDR_W:0]  foff_diff;
  logic [PG_W-1:0]  fc_page;
  logic [PI_W-1:0]  fc_first;
  logic [FS_W-1:0]  fc_sum;
  logic             fc_bad;

  always_comb begin
    foff_diff = {1'b0, address_reg} - {1'b0, mem_base};
    fc_page   = free_off[ADDR_W-1:PB_SH];
    fc_first  = PI_W'(fc_page);
    fc_sum    = FS_W'(fc_first) + FS_W'(count_reg);
    fc_bad    = free_below
             || (free_off[PB_SH-1:0] != '0)
             || (fc_page >= PG_W'(PAGE_COUNT))
             || (fc_sum > FS_W'(PAGE_COUNT));
  end

  // ---------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_INIT;
      mem_base       <= bpa_pkg::MEM_BASE_RESET;
      held_pages     <= bpa_pkg::RESERVED_RESET;
      sweep_n        <= '0;
      init_reply     <= 1'b0;
      rd_word        <= '0;
      rd_active      <= 1'b0;
      p1_valid       <= 1'b0;
      p2_valid       <= 1'b0;
      response_valid <= 1'b0;
    end else begin
      // configuration, to be written only while idle; the block itself does not enforce this
      if (write_enable) begin
        unique case (bpa_pkg::reg_index_t'(register_index))
          bpa_pkg::REG_MEM_BASE:   mem_base   <= write_data;
          bpa_pkg::REG_HELD_PAGES: held_pages <= write_data[CNT_W-1:0];
        endcase
      end

      if (response_valid && !response_stall) begin
        response_valid <= 1'b0;
      end

      unique case (state)
        S_INIT: begin
          if (rd_word == LAST_WORD) begin
            res_status <= 1'b0;
            res_addr   <= '0;
            state      <= init_reply ? S_RESP : S_IDLE;
          end else begin
            rd_word <= rd_word + AW'(1);
          end
        end

        S_IDLE: begin
          if (request_xfer) begin
            count_reg   <= page_count;
            address_reg <= address;
            res_status  <= 1'b0;
            res_addr    <= '0;
            unique case (bpa_pkg::op_t'(operation))
              bpa_pkg::OP_INIT: begin
                sweep_n    <= (CMP_W'(held_pages) > PC_C) ? PC_C
                                                          : CMP_W'(held_pages);
                init_reply <= 1'b1;
                rd_word    <= '0;
                state      <= S_INIT;
              end
              bpa_pkg::OP_ALLOC: begin
                if ((page_count == '0) || (CMP_W'(page_count) > PC_C)) begin
                  res_status <= 1'b1;
                  state      <= S_RESP;
                end else begin
                  rd_word   <= '0;
                  rd_active <= 1'b1;
                  p1_valid  <= 1'b0;
                  p2_valid  <= 1'b0;
                  r_in      <= '0;
                  state     <= S_SCAN;
                end
              end
              bpa_pkg::OP_FREE: begin
                state <= S_FOFF;
              end
              bpa_pkg::OP_NONE: begin
                res_status <= 1'b1;
                state      <= S_RESP;
              end
            endcase
          end
        end

        S_SCAN: begin
          if (rd_active) begin
            rd_active <= (rd_word != LAST_WORD);
            rd_word   <= rd_word + AW'(1);
          end
          p1_valid <= rd_active;
          p1_word  <= rd_word;
          p2_valid <= p1_valid;
          p2_word  <= p1_word;
          for (int b = 0; b < W; b++) begin
            a_has[b]  <= pf_has[LOG_W][b];
            a_dist[b] <= sa_dist[b];
          end
          if (p2_valid) begin
            if (sb_found) begin
              run_lo    <= sb_first;
              run_hi    <= sb_end;
              rd_active <= 1'b0;
              p1_valid  <= 1'b0;
              p2_valid  <= 1'b0;
              state     <= S_ADDR;
            end else if (p2_word == LAST_WORD) begin
              res_status <= 1'b1;
              rd_active  <= 1'b0;
              p1_valid   <= 1'b0;
              p2_valid   <= 1'b0;
              state      <= S_RESP;
            end else begin
              r_in <= r_out;
            end
          end
        end

        S_ADDR: begin
          res_addr  <= mem_base + ADDR_W'({run_lo, {PB_SH{1'b0}}});
          set_mode  <= 1'b1;
          rd_word   <= lo_word;
          rd_active <= 1'b1;
          p1_valid  <= 1'b0;
          state     <= S_RMW;
        end

        S_FOFF: begin
          free_below <= foff_diff[ADDR_W];
          free_off   <= foff_diff[ADDR_W-1:0];
          state      <= S_FCHK;
        end

        S_FCHK: begin
          if (fc_bad) begin
            res_status <= 1'b1;
            state      <= S_RESP;
          end else if (count_reg == '0) begin
            state <= S_RESP;
          end else begin
            run_lo    <= fc_first;
            run_hi    <= PI_W'(fc_sum - FS_W'(1));
            set_mode  <= 1'b0;
            rd_word   <= fc_first[PI_W-1:LOG_W];
            rd_active <= 1'b1;
            p1_valid  <= 1'b0;
            state     <= S_RMW;
          end
        end

        S_RMW: begin
          if (rd_active) begin
            rd_active <= (rd_word != hi_word);
            rd_word   <= rd_word + AW'(1);
          end
          p1_valid <= rd_active;
          p1_word  <= rd_word;
          if (p1_valid && (p1_word == hi_word)) begin
            rd_active <= 1'b0;
            p1_valid  <= 1'b0;
            state     <= S_RESP;
          end
        end

        S_RESP: begin
          if (!response_valid || !response_stall) begin
            response_valid <= 1'b1;
            status         <= res_status;
            page_address   <= res_addr;
            init_reply     <= 1'b0;
            state          <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule
